// ===== src/sdrb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sweep display ring buffer: item types, command codes and
// FSM state type. No dependencies.
`default_nettype none

package sdrb_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CMD_W    = 2;
  localparam int SHIFT_W  = 12;
  localparam int OFFSET_W = 10;
  localparam int POINTS_W = 10;
  localparam int CFG_W    = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SHIFT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_NEW = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_OLD = 2'd3;

  typedef struct packed {
    logic        [CMD_W-1:0]    command;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SHIFT_W-1:0]  shift_amount;
    logic        [OFFSET_W-1:0] read_offset;
  } sdrb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] read_value;
    logic                       read_valid;
    logic                       sweep_done;
    logic        [POINTS_W-1:0] new_points;
  } sdrb_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SHFIX,
    ST_SHSTART,
    ST_RADDR,
    ST_OUT
  } sdrb_state_t;

endpackage

`default_nettype wire

// ===== src/sweep_display_ring_buffer_core.sv =====
`timescale 1ns / 1ps
// Sweep chart ring store: top level with control FSM, remainder unit and
// sample memory. Depends on sdrb_pkg and sdrb_ram.
//
// Usage:
//   in_valid/in_stall carry one command item (push, shift, read new segment,
//   read old segment); out_valid/out_stall return exactly one result item
//   per command. cfg_we/cfg_wdata write display_points, which restarts the
//   sweep after the current position; write it only while no item is open.
//   Items are handled one at a time. A push writes the sample; a read issues
//   a registered memory read if its offset lies in the segment; a shift runs
//   the remainder unit, which retires one bit of its SW-bit dividend per
//   cycle (SW = 13 at the default depth), then fixes the remainder and moves
//   the start. A new item is accepted in the cycle after the result is
//   loaded, even while it waits. After reset a clearing pass writes zero to
//   every sample slot; in_stall stays high during it.
//   When the receiver stalls, the result holds in the output register and
//   the next item stalls at its final step until the register frees.
`default_nettype none

module sweep_display_ring_buffer_core
  import sdrb_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sdrb_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sdrb_out_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CFG_MAX  = (1 << CFG_W) - 1;
  localparam int DP_MAX   = (DEPTH > CFG_MAX) ? CFG_MAX : DEPTH;
  localparam int DP_RST   = (DEPTH < 1024) ? DEPTH : 1024;
  localparam int PW       = $clog2(DP_MAX + 1);
  localparam int XW       = ((AW > PW) ? AW : PW) + 2;
  localparam int SW       = ((PW + 1 > SHIFT_W) ? PW + 1 : SHIFT_W) + 1;
  localparam int DCW      = $clog2(SW + 1);
  localparam int CMPW     = (PW > OFFSET_W) ? PW : OFFSET_W;
  localparam logic signed [XW-1:0] DEPTH_S = XW'(DEPTH);

  // Bring a value in (-DEPTH, 2*DEPTH) back onto the ring
  function automatic logic [AW-1:0] wrap_ring(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    y = x;
    if (x < 0) begin
      y = x + DEPTH_S;
    end else if (x >= DEPTH_S) begin
      y = x - DEPTH_S;
    end
    return y[AW-1:0];
  endfunction

  sdrb_state_t     state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  sdrb_in_t        item_r, item_nxt;
  logic [AW-1:0]   start_r, start_nxt;
  logic [PW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   dp_r, dp_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [SW-1:0]   dvd_r, dvd_nxt;
  logic            neg_r, neg_nxt;
  logic [DCW-1:0]  div_cnt_r, div_cnt_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [PW-1:0]   len_r, len_nxt;
  logic            rd_valid_r, rd_valid_nxt;
  logic            done_r, done_nxt;
  logic            out_valid_r, out_valid_nxt;
  sdrb_out_t       out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                out_free;
  logic [AW-1:0]       slot;
  logic [PW:0]         cnt_inc;
  logic signed [SW-1:0] sh_sum;
  logic [PW:0]         rem_sh;
  logic [PW-1:0]       dp_cfg;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Shared datapath terms
  assign slot    = wrap_ring($signed(XW'(start_r)) + $signed(XW'(count_r)));
  assign cnt_inc = {1'b0, count_r} + (PW + 1)'(1);
  assign sh_sum  = SW'(item_r.shift_amount) + $signed(SW'(count_r));
  assign rem_sh  = {rem_r, dvd_r[SW-1]};

  // Saturate a written point count into 1..DP_MAX, the smaller of DEPTH and 2**CFG_W-1
  always_comb begin
    if (cfg_wdata == '0) begin
      dp_cfg = PW'(1);
    end else if (int'(cfg_wdata) > DP_MAX) begin
      dp_cfg = PW'(DP_MAX);
    end else begin
      dp_cfg = PW'(cfg_wdata);
    end
  end

  sdrb_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (item_r.command)
          CMD_PUSH:  state_nxt = ST_OUT;
          CMD_SHIFT: state_nxt = ST_DIV;
          default:   state_nxt = ST_RADDR;
        endcase
      end
      ST_DIV: begin
        if (div_cnt_r == DCW'(1)) begin
          state_nxt = ST_SHFIX;
        end
      end
      ST_SHFIX:   state_nxt = ST_SHSTART;
      ST_SHSTART: state_nxt = ST_OUT;
      ST_RADDR:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    dp_nxt        = dp_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    neg_nxt       = neg_r;
    div_cnt_nxt   = div_cnt_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    rd_valid_nxt  = rd_valid_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = slot;
    ram_wdata     = item_r.sample;
    ram_re        = 1'b0;
    ram_raddr     = wrap_ring($signed(XW'(base_r)) + $signed(XW'(item_r.read_offset)));

    // Drop the output item once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      ST_EXEC: begin
        rd_valid_nxt = 1'b0;
        done_nxt     = 1'b0;
        unique case (item_r.command)
          CMD_PUSH: begin
            // Write after the current position; restart the sweep when full
            ram_we = 1'b1;
            if (cnt_inc >= {1'b0, dp_r}) begin
              start_nxt = wrap_ring($signed(XW'(slot)) + XW'(1));
              count_nxt = '0;
              done_nxt  = 1'b1;
            end else begin
              count_nxt = cnt_inc[PW-1:0];
            end
          end
          CMD_SHIFT: begin
            // Load the remainder unit with the magnitude of the new count
            neg_nxt     = sh_sum < 0;
            dvd_nxt     = (sh_sum < 0) ? SW'(-sh_sum) : SW'(sh_sum);
            rem_nxt     = '0;
            div_cnt_nxt = DCW'(SW);
          end
          CMD_READ_NEW: begin
            base_nxt = start_r;
            len_nxt  = count_r;
          end
          default: begin
            base_nxt = wrap_ring($signed(XW'(start_r)) + $signed(XW'(count_r))
                                 - $signed(XW'(dp_r)));
            len_nxt  = dp_r - count_r;
          end
        endcase
      end
      ST_DIV: begin
        // One restoring step per cycle
        if (rem_sh >= {1'b0, dp_r}) begin
          rem_nxt = PW'(rem_sh - {1'b0, dp_r});
        end else begin
          rem_nxt = rem_sh[PW-1:0];
        end
        dvd_nxt     = dvd_r << 1;
        div_cnt_nxt = div_cnt_r - DCW'(1);
      end
      ST_SHFIX: begin
        // Fold a negative remainder into 0..display_points-1
        if (neg_r && rem_r != '0) begin
          rem_nxt = dp_r - rem_r;
        end
      end
      ST_SHSTART: begin
        // Move the start so the current position stays
        start_nxt = wrap_ring($signed(XW'(start_r)) + $signed(XW'(count_r))
                              - $signed(XW'(rem_r)));
        count_nxt = rem_r;
        done_nxt  = (rem_r == '0);
      end
      ST_RADDR: begin
        if (CMPW'(item_r.read_offset) < CMPW'(len_r)) begin
          ram_re       = 1'b1;
          rd_valid_nxt = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.read_value = rd_valid_r ? ram_rdata : '0;
          out_nxt.read_valid = rd_valid_r;
          out_nxt.sweep_done = done_r;
          out_nxt.new_points = POINTS_W'(count_r);
        end
      end
      default: begin
      end
    endcase

    // Restart the sweep on a point count write
    if (cfg_we) begin
      dp_nxt    = dp_cfg;
      start_nxt = slot;
      count_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      start_r     <= '0;
      count_r     <= '0;
      dp_r        <= PW'(DP_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      start_r     <= start_nxt;
      count_r     <= count_nxt;
      dp_r        <= dp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    neg_r      <= neg_nxt;
    div_cnt_r  <= div_cnt_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    rd_valid_r <= rd_valid_nxt;
    done_r     <= done_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTH
  a_out_from_final_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result item appeared outside the final step");

  a_count_below_points: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_r != '0) && (count_r < dp_r))
    else $error("new point count not below display points");

  a_start_on_ring: assert property (@(posedge clk) disable iff (!rst_n)
    $signed(XW'(start_r)) < DEPTH_S)
    else $error("sweep start outside the ring");
`endif

endmodule

`default_nettype wire

// ===== src/sdrb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sdrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
